>>> hdl/vsc_pkg.sv
// shared types, constants and the control store for the version string compare block
// no dependencies
`timescale 1ns / 1ps

package vsc_pkg;

   localparam int MAX_LEN_DEFAULT = 64;

   localparam int CHAR_W = 8;
   localparam int DIFF_W = 9;
   localparam int PC_W   = 4;
   localparam int COND_W = 4;
   localparam int OP_W   = 3;

   localparam logic [CHAR_W-1:0] CHAR_NUL  = 8'h00;
   localparam logic [CHAR_W-1:0] CHAR_ZERO = 8'h30;
   localparam logic [CHAR_W-1:0] CHAR_NINE = 8'h39;
   localparam logic [CHAR_W-1:0] CHAR_A    = 8'h61;
   localparam logic [CHAR_W-1:0] CHAR_N    = 8'h6e;
   localparam logic [CHAR_W-1:0] CHAR_Y    = 8'h79;

   // branch conditions
   localparam logic [COND_W-1:0] C_NEVER     = 4'd0;
   localparam logic [COND_W-1:0] C_WILD      = 4'd1;
   localparam logic [COND_W-1:0] C_NEW_DIG   = 4'd2;
   localparam logic [COND_W-1:0] C_CONT      = 4'd3;
   localparam logic [COND_W-1:0] C_A_ZERO    = 4'd4;
   localparam logic [COND_W-1:0] C_B_ZERO    = 4'd5;
   localparam logic [COND_W-1:0] C_BOTH_DIG  = 4'd6;
   localparam logic [COND_W-1:0] C_DIG_EQ    = 4'd7;
   localparam logic [COND_W-1:0] C_DIFF_ZERO = 4'd8;

   // datapath operations
   localparam logic [OP_W-1:0] OP_NONE     = 3'd0;
   localparam logic [OP_W-1:0] OP_CLR_DIFF = 3'd1;
   localparam logic [OP_W-1:0] OP_SET_DIFF = 3'd2;
   localparam logic [OP_W-1:0] OP_RET_AB   = 3'd3;
   localparam logic [OP_W-1:0] OP_RET_SIGN = 3'd4;
   localparam logic [OP_W-1:0] OP_RET_DIFF = 3'd5;
   localparam logic [OP_W-1:0] OP_RET_ZERO = 3'd6;

   // program step addresses
   localparam logic [PC_W-1:0] S_WILD     = 4'd0;
   localparam logic [PC_W-1:0] S_NEXT     = 4'd1;
   localparam logic [PC_W-1:0] S_TEST     = 4'd2;
   localparam logic [PC_W-1:0] S_RET_AB   = 4'd3;
   localparam logic [PC_W-1:0] S_ZA       = 4'd4;
   localparam logic [PC_W-1:0] S_ZB       = 4'd5;
   localparam logic [PC_W-1:0] S_RUN      = 4'd6;
   localparam logic [PC_W-1:0] S_END      = 4'd7;
   localparam logic [PC_W-1:0] S_RET_SIGN = 4'd8;
   localparam logic [PC_W-1:0] S_CHK      = 4'd9;
   localparam logic [PC_W-1:0] S_RET_DIFF = 4'd10;
   localparam logic [PC_W-1:0] S_ZERO     = 4'd11;

   typedef struct packed {
      logic              fetch_a;
      logic              fetch_b;
      logic              guard;    // fetch and op only when the branch is taken
      logic [COND_W-1:0] cond;
      logic [PC_W-1:0]   target;
      logic [OP_W-1:0]   op;
   } ucode_word_type;

   // sequencer to datapath
   typedef struct packed {
      logic            fetch_a;
      logic            fetch_b;
      logic [OP_W-1:0] op;
      logic            done;
   } ctrl_type;

   // datapath to sequencer
   typedef struct packed {
      logic wild;
      logic new_both_dig;
      logic both_dig;
      logic cont;
      logic a_zero;
      logic b_zero;
      logic dig_eq;
      logic diff_zero;
   } flags_type;

   function automatic logic is_digit(input logic [CHAR_W-1:0] c);
      return (c >= CHAR_ZERO) && (c <= CHAR_NINE);
   endfunction

   function automatic ucode_word_type mk(input logic fa, input logic fb, input logic g,
                                         input logic [COND_W-1:0] c,
                                         input logic [PC_W-1:0] t,
                                         input logic [OP_W-1:0] o);
      ucode_word_type w;
      w.fetch_a = fa;
      w.fetch_b = fb;
      w.guard   = g;
      w.cond    = c;
      w.target  = t;
      w.op      = o;
      return w;
   endfunction

   // control store: branch taken goes to target, otherwise to the next step
   function automatic ucode_word_type ucode(input logic [PC_W-1:0] pc);
      ucode_word_type w;
      case (pc)
         S_WILD:     w = mk(1'b0, 1'b0, 1'b0, C_WILD,      S_ZERO, OP_NONE);
         S_NEXT:     w = mk(1'b1, 1'b1, 1'b0, C_NEW_DIG,   S_ZA,   OP_CLR_DIFF);
         S_TEST:     w = mk(1'b0, 1'b0, 1'b0, C_CONT,      S_NEXT, OP_NONE);
         S_RET_AB:   w = mk(1'b0, 1'b0, 1'b0, C_NEVER,     S_WILD, OP_RET_AB);
         S_ZA:       w = mk(1'b1, 1'b0, 1'b1, C_A_ZERO,    S_ZA,   OP_NONE);
         S_ZB:       w = mk(1'b0, 1'b1, 1'b1, C_B_ZERO,    S_ZB,   OP_NONE);
         S_RUN:      w = mk(1'b1, 1'b1, 1'b1, C_BOTH_DIG,  S_RUN,  OP_SET_DIFF);
         S_END:      w = mk(1'b0, 1'b0, 1'b0, C_DIG_EQ,    S_CHK,  OP_NONE);
         S_RET_SIGN: w = mk(1'b0, 1'b0, 1'b0, C_NEVER,     S_WILD, OP_RET_SIGN);
         S_CHK:      w = mk(1'b0, 1'b0, 1'b0, C_DIFF_ZERO, S_TEST, OP_NONE);
         S_RET_DIFF: w = mk(1'b0, 1'b0, 1'b0, C_NEVER,     S_WILD, OP_RET_DIFF);
         S_ZERO:     w = mk(1'b0, 1'b0, 1'b0, C_NEVER,     S_WILD, OP_RET_ZERO);
         default:    w = mk(1'b0, 1'b0, 1'b0, C_NEVER,     S_WILD, OP_RET_ZERO);
      endcase
      return w;
   endfunction

endpackage

>>> hdl/vsc_char_buf.sv
// one string buffer: character memory, fill count and "any" detection
// depends on vsc_pkg
`timescale 1ns / 1ps

module vsc_char_buf #(
   parameter int MAX_LEN = vsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                                  clock,
   input  logic                                  reset,
   input  logic                                  clear,
   input  logic                                  wr_valid,
   input  logic [vsc_pkg::CHAR_W-1:0]            wr_char,
   input  logic [$clog2(MAX_LEN+1):0]            rd_idx,   // index read in the next cycle
   output logic [vsc_pkg::CHAR_W-1:0]            rd_char,  // zero past the fill count
   output logic                                  full,
   output logic                                  wild
);

   localparam int LEN_W  = $clog2(MAX_LEN + 1);
   localparam int ADDR_W = $clog2(MAX_LEN);

   logic [vsc_pkg::CHAR_W-1:0] mem [MAX_LEN];
   logic [vsc_pkg::CHAR_W-1:0] data_ff;
   logic                       valid_ff, valid_in;
   logic [LEN_W-1:0]           len_ff, len_in;
   logic                       wild_ff, wild_in;
   logic                       wr_en;

   assign full  = (len_ff == LEN_W'(MAX_LEN));
   assign wr_en = wr_valid && !full;

   always_comb begin
      len_in  = len_ff;
      wild_in = wild_ff;
      if (clear) begin
         len_in  = '0;
         wild_in = 1'b0;
      end else if (wr_en) begin
         len_in = len_ff + LEN_W'(1);
         if (len_ff == LEN_W'(0)) begin
            wild_in = (wr_char == vsc_pkg::CHAR_A);
         end else if (len_ff == LEN_W'(1)) begin
            wild_in = wild_ff && (wr_char == vsc_pkg::CHAR_N);
         end else if (len_ff == LEN_W'(2)) begin
            wild_in = wild_ff && (wr_char == vsc_pkg::CHAR_Y);
         end
      end
   end

   assign valid_in = (rd_idx < {1'b0, len_ff});

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         wild_ff  <= 1'b0;
         valid_ff <= 1'b0;
      end else begin
         len_ff   <= len_in;
         wild_ff  <= wild_in;
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[len_ff[ADDR_W-1:0]] <= wr_char;
      end
      data_ff <= mem[rd_idx[ADDR_W-1:0]];
   end

   assign rd_char = valid_ff ? data_ff : vsc_pkg::CHAR_NUL;
   assign wild    = wild_ff && (len_ff == LEN_W'(3));

endmodule

>>> hdl/vsc_datapath.sv
// compare datapath: scan indices, current characters, digit difference, result
// depends on vsc_pkg
`timescale 1ns / 1ps

module vsc_datapath #(
   parameter int MAX_LEN = vsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  vsc_pkg::ctrl_type                  ctrl,
   input  logic [vsc_pkg::CHAR_W-1:0]         char_a,
   input  logic [vsc_pkg::CHAR_W-1:0]         char_b,
   input  logic                               wild_a,
   input  logic                               wild_b,
   output logic [$clog2(MAX_LEN+1):0]         idx_a_next,
   output logic [$clog2(MAX_LEN+1):0]         idx_b_next,
   output vsc_pkg::flags_type                 flags,
   output logic signed [vsc_pkg::DIFF_W-1:0]  result
);

   localparam int IDX_W = $clog2(MAX_LEN + 1) + 1;

   logic [IDX_W-1:0]                   i_ff, i_in, j_ff, j_in;
   logic [vsc_pkg::CHAR_W-1:0]         a_ff, a_in, b_ff, b_in;
   logic signed [vsc_pkg::DIFF_W-1:0]  diff_ff, diff_in;
   logic signed [vsc_pkg::DIFF_W-1:0]  a_minus_b;
   logic                               dig_a, dig_b;

   assign a_minus_b = $signed({1'b0, a_ff}) - $signed({1'b0, b_ff});
   assign dig_a     = vsc_pkg::is_digit(a_ff);
   assign dig_b     = vsc_pkg::is_digit(b_ff);

   always_comb begin
      i_in = i_ff;
      j_in = j_ff;
      a_in = a_ff;
      b_in = b_ff;
      if (ctrl.done) begin
         i_in = '0;
         j_in = '0;
      end else begin
         if (ctrl.fetch_a) begin
            i_in = i_ff + IDX_W'(1);
            a_in = char_a;
         end
         if (ctrl.fetch_b) begin
            j_in = j_ff + IDX_W'(1);
            b_in = char_b;
         end
      end
   end

   always_comb begin
      diff_in = diff_ff;
      case (ctrl.op)
         vsc_pkg::OP_CLR_DIFF: diff_in = '0;
         vsc_pkg::OP_SET_DIFF: begin
            if (diff_ff == '0) begin
               diff_in = a_minus_b;
            end
         end
         default: diff_in = diff_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         i_ff <= '0;
         j_ff <= '0;
      end else begin
         i_ff <= i_in;
         j_ff <= j_in;
      end
   end

   always_ff @(posedge clock) begin
      a_ff    <= a_in;
      b_ff    <= b_in;
      diff_ff <= diff_in;
   end

   assign idx_a_next = i_in;
   assign idx_b_next = j_in;

   always_comb begin
      flags.wild         = wild_a || wild_b;
      flags.new_both_dig = vsc_pkg::is_digit(char_a) && vsc_pkg::is_digit(char_b);
      flags.both_dig     = dig_a && dig_b;
      flags.cont         = (a_ff != vsc_pkg::CHAR_NUL) && (b_ff != vsc_pkg::CHAR_NUL)
                           && (a_ff == b_ff);
      flags.a_zero       = (a_ff == vsc_pkg::CHAR_ZERO);
      flags.b_zero       = (b_ff == vsc_pkg::CHAR_ZERO);
      flags.dig_eq       = (dig_a == dig_b);
      flags.diff_zero    = (diff_ff == '0);
   end

   always_comb begin
      case (ctrl.op)
         vsc_pkg::OP_RET_AB:   result = a_minus_b;
         vsc_pkg::OP_RET_SIGN: result = dig_a ? 9'sd1 : -9'sd1;
         vsc_pkg::OP_RET_DIFF: result = diff_ff;
         default:              result = '0;
      endcase
   end

endmodule

>>> hdl/vsc_sequencer.sv
// microprogram sequencer: step counter, control store lookup, conditional jumps
// depends on vsc_pkg
`timescale 1ns / 1ps

module vsc_sequencer (
   input  logic               clock,
   input  logic               reset,
   input  logic               start,
   input  vsc_pkg::flags_type flags,
   output vsc_pkg::ctrl_type  ctrl,
   output logic               busy
);

   logic                       busy_ff, busy_in;
   logic [vsc_pkg::PC_W-1:0]   pc_ff, pc_in;
   vsc_pkg::ucode_word_type    cw;
   logic                       take;
   logic                       en;
   logic                       is_ret;

   assign cw = vsc_pkg::ucode(pc_ff);

   always_comb begin
      case (cw.cond)
         vsc_pkg::C_WILD:      take = flags.wild;
         vsc_pkg::C_NEW_DIG:   take = flags.new_both_dig;
         vsc_pkg::C_CONT:      take = flags.cont;
         vsc_pkg::C_A_ZERO:    take = flags.a_zero;
         vsc_pkg::C_B_ZERO:    take = flags.b_zero;
         vsc_pkg::C_BOTH_DIG:  take = flags.both_dig;
         vsc_pkg::C_DIG_EQ:    take = flags.dig_eq;
         vsc_pkg::C_DIFF_ZERO: take = flags.diff_zero;
         default:              take = 1'b0;
      endcase
   end

   assign en     = busy_ff && (!cw.guard || take);
   assign is_ret = (cw.op == vsc_pkg::OP_RET_AB) || (cw.op == vsc_pkg::OP_RET_SIGN) ||
                   (cw.op == vsc_pkg::OP_RET_DIFF) || (cw.op == vsc_pkg::OP_RET_ZERO);

   always_comb begin
      ctrl.fetch_a = en && cw.fetch_a;
      ctrl.fetch_b = en && cw.fetch_b;
      ctrl.op      = en ? cw.op : vsc_pkg::OP_NONE;
      ctrl.done    = busy_ff && is_ret;
   end

   always_comb begin
      busy_in = busy_ff;
      pc_in   = pc_ff;
      if (start) begin
         busy_in = 1'b1;
         pc_in   = vsc_pkg::S_WILD;
      end else if (busy_ff) begin
         if (is_ret) begin
            busy_in = 1'b0;
            pc_in   = vsc_pkg::S_WILD;
         end else if (take) begin
            pc_in = cw.target;
         end else begin
            pc_in = pc_ff + vsc_pkg::PC_W'(1);
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         pc_ff   <= vsc_pkg::S_WILD;
      end else begin
         busy_ff <= busy_in;
         pc_ff   <= pc_in;
      end
   end

   assign busy = busy_ff;

endmodule

>>> hdl/version_string_compare.sv
// top level of the natural-order version string compare block
// depends on vsc_pkg, vsc_char_buf, vsc_datapath, vsc_sequencer
`timescale 1ns / 1ps

//  channel | direction | handshake             | payload
//  req     | in        | req_valid / req_ready | req_mode, req_char_code
//  rsp     | out       | rsp_valid / rsp_ready | rsp_difference, rsp_truncated
//
//  loading accepts one character transaction per cycle while req_ready is high; the
//  second string's zero byte starts the compare walk: a setup step checks for "any",
//  each equal non-digit character is fetched and tested, each digit run skips leading
//  zeros, walks its digit pairs, checks that both runs end together and compares the
//  difference, and a return step ends the walk; no transaction is taken while the walk
//  runs; the result sits in the output register, and characters keep loading while it
//  waits, only the next second-string zero byte stalls until the result is taken
//  synchronous active-high reset clears fill counts, overflow flag, sequencer and rsp_valid

module version_string_compare #(
   parameter int MAX_LEN = vsc_pkg::MAX_LEN_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic                               req_mode,
   input  logic [vsc_pkg::CHAR_W-1:0]         req_char_code,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic signed [vsc_pkg::DIFF_W-1:0]  rsp_difference,
   output logic                               rsp_truncated
);

   localparam int IDX_W = $clog2(MAX_LEN + 1) + 1;

   logic                              req_fire, rsp_fire;
   logic                              is_nul, is_final;
   logic                              start;
   logic                              busy;
   logic                              wr_a, wr_b;
   logic                              full_a, full_b;
   logic                              wild_a, wild_b;
   logic [vsc_pkg::CHAR_W-1:0]        char_a, char_b;
   logic [IDX_W-1:0]                  idx_a_next, idx_b_next;
   vsc_pkg::ctrl_type                 ctrl;
   vsc_pkg::flags_type                flags;
   logic signed [vsc_pkg::DIFF_W-1:0] result;

   logic                              overflow_ff, overflow_in;
   logic                              rsp_valid_ff, rsp_valid_in;
   logic signed [vsc_pkg::DIFF_W-1:0] rsp_diff_ff;
   logic                              rsp_trunc_ff;

   // a second-string zero byte needs a free output register
   assign is_nul    = (req_char_code == vsc_pkg::CHAR_NUL);
   assign is_final  = req_mode && is_nul;
   assign req_ready = !busy && !(is_final && rsp_valid_ff);
   assign req_fire  = req_valid && req_ready;
   assign rsp_fire  = rsp_valid_ff && rsp_ready;

   assign start = req_fire && is_final;
   assign wr_a  = req_fire && !req_mode && !is_nul;
   assign wr_b  = req_fire && req_mode && !is_nul;

   vsc_char_buf #(.MAX_LEN(MAX_LEN)) u_buf_a (
      .clock    (clock),
      .reset    (reset),
      .clear    (ctrl.done),
      .wr_valid (wr_a),
      .wr_char  (req_char_code),
      .rd_idx   (idx_a_next),
      .rd_char  (char_a),
      .full     (full_a),
      .wild     (wild_a)
   );

   vsc_char_buf #(.MAX_LEN(MAX_LEN)) u_buf_b (
      .clock    (clock),
      .reset    (reset),
      .clear    (ctrl.done),
      .wr_valid (wr_b),
      .wr_char  (req_char_code),
      .rd_idx   (idx_b_next),
      .rd_char  (char_b),
      .full     (full_b),
      .wild     (wild_b)
   );

   vsc_datapath #(.MAX_LEN(MAX_LEN)) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .ctrl       (ctrl),
      .char_a     (char_a),
      .char_b     (char_b),
      .wild_a     (wild_a),
      .wild_b     (wild_b),
      .idx_a_next (idx_a_next),
      .idx_b_next (idx_b_next),
      .flags      (flags),
      .result     (result)
   );

   vsc_sequencer u_sequencer (
      .clock (clock),
      .reset (reset),
      .start (start),
      .flags (flags),
      .ctrl  (ctrl),
      .busy  (busy)
   );

   // dropped characters of either string flag the pair
   always_comb begin
      overflow_in = overflow_ff;
      if (ctrl.done) begin
         overflow_in = 1'b0;
      end else if ((wr_a && full_a) || (wr_b && full_b)) begin
         overflow_in = 1'b1;
      end
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (ctrl.done) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_fire) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         overflow_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         overflow_ff  <= overflow_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (ctrl.done) begin
         rsp_diff_ff  <= result;
         rsp_trunc_ff <= overflow_ff;
      end
   end

   assign rsp_valid      = rsp_valid_ff;
   assign rsp_difference = rsp_diff_ff;
   assign rsp_truncated  = rsp_trunc_ff;

endmodule
